[design/stepper_step_dir_generator_macros.svh]
// Assertion macros used by the checker of the step/dir generator.
`ifndef STEPPER_STEP_DIR_GENERATOR_MACROS_SVH
`define STEPPER_STEP_DIR_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SSDG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ssdg_pkg.sv]
`timescale 1ns / 1ps

package ssdg_pkg;

    // Field widths fixed by the interface
    localparam int POS_W      = 16;
    localparam int PERIOD_W   = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Item operation codes
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_START       = 2'd1;
    localparam logic [1:0] OP_START_LIMIT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD_US   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRECTION = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVER_ENABLE    = 4'd3;

    // Configuration reset values
    localparam logic [POS_W-1:0]    RST_STEPS_PER_REV  = 16'd200;
    localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD_US = 24'd1000;

    typedef struct packed {
        logic [POS_W-1:0]    steps_per_rev;
        logic [PERIOD_W-1:0] step_period_us;
        logic                invert_direction;
        logic                driver_enable;
    } cfg_t;

    typedef struct packed {
        logic             step_level;
        logic             dir_level;
        logic             busy;
        logic             halted;
        logic [POS_W-1:0] position;
    } status_t;

endpackage

[design/ssdg_cfg_regs.sv]
`timescale 1ns / 1ps

module ssdg_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [ssdg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssdg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ssdg_pkg::cfg_t                    cfg
);

    ssdg_pkg::cfg_t cfg_reg;
    ssdg_pkg::cfg_t cfg_next;

    // Decode a register write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ssdg_pkg::REG_STEPS_PER_REV:
                    cfg_next.steps_per_rev = cfg_data[ssdg_pkg::POS_W-1:0];
                ssdg_pkg::REG_STEP_PERIOD_US:
                    cfg_next.step_period_us = cfg_data[ssdg_pkg::PERIOD_W-1:0];
                ssdg_pkg::REG_INVERT_DIRECTION:
                    cfg_next.invert_direction = cfg_data[0];
                ssdg_pkg::REG_DRIVER_ENABLE:
                    cfg_next.driver_enable = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_rev    <= ssdg_pkg::RST_STEPS_PER_REV;
            cfg_reg.step_period_us   <= ssdg_pkg::RST_STEP_PERIOD_US;
            cfg_reg.invert_direction <= 1'b0;
            cfg_reg.driver_enable    <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/ssdg_in_stage.sv]
`timescale 1ns / 1ps

module ssdg_in_stage
#(
    parameter int MOVE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [MOVE_BITS-1:0] move_steps,
    input  logic                 stop_level,
    input  logic                 limit_level,
    input  logic                 advance,
    output logic                 item_valid,
    output logic [1:0]           op_q,
    output logic [MOVE_BITS-1:0] move_q,
    output logic                 stop_q,
    output logic                 limit_q
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [1:0]           op_reg;
    logic [MOVE_BITS-1:0] move_reg;
    logic                 stop_reg;
    logic                 limit_reg;
    logic                 in_fire;

    // Take a new item when the register is empty or the held one moves on this cycle
    assign in_ready = !valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_fire)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= op;
            move_reg  <= move_steps;
            stop_reg  <= stop_level;
            limit_reg <= limit_level;
        end
    end

    assign item_valid = valid_reg;
    assign op_q       = op_reg;
    assign move_q     = move_reg;
    assign stop_q     = stop_reg;
    assign limit_q    = limit_reg;

endmodule

[design/ssdg_motion_core.sv]
`timescale 1ns / 1ps

module ssdg_motion_core
#(
    parameter int MOVE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [1:0]           op,
    input  logic [MOVE_BITS-1:0] move_steps,
    input  logic                 stop_level,
    input  logic                 limit_level,
    input  ssdg_pkg::cfg_t       cfg,
    output ssdg_pkg::status_t    status_next
);

    localparam int POS_W    = ssdg_pkg::POS_W;
    localparam int PERIOD_W = ssdg_pkg::PERIOD_W;

    logic [POS_W-1:0]    position_reg,    position_next;
    logic [MOVE_BITS:0]  remaining_reg,   remaining_next;
    logic [PERIOD_W-1:0] period_reg,      period_next;
    logic                direction_reg,   direction_next;
    logic                moving_reg,      moving_next;
    logic                armed_reg,       armed_next;
    logic                armed_level_reg, armed_level_next;
    logic                halted_reg,      halted_next;

    logic                 negative;
    logic [MOVE_BITS-1:0] magnitude;
    logic                 move_zero;
    logic [PERIOD_W:0]    period_sum;
    logic                 period_end;
    logic [POS_W-1:0]     pos_inc;
    logic [POS_W-1:0]     pos_up;
    logic [POS_W-1:0]     pos_base;
    logic [POS_W-1:0]     pos_down;
    logic [MOVE_BITS:0]   remaining_dec;

    // Magnitude of the move; the most negative count maps onto the sign weight
    assign negative  = move_steps[MOVE_BITS-1];
    assign magnitude = negative ? MOVE_BITS'(~move_steps + 1'b1) : move_steps;
    assign move_zero = (move_steps == '0);

    // Period end when the next count reaches the period
    assign period_sum = {1'b0, period_reg} + {{PERIOD_W{1'b0}}, 1'b1};
    assign period_end = (period_sum >= {1'b0, cfg.step_period_us});

    // Position one half-step up or down, wrapping at steps_per_rev
    assign pos_inc  = position_reg + POS_W'(1);
    assign pos_up   = (pos_inc == cfg.steps_per_rev) ? '0 : pos_inc;
    assign pos_base = (position_reg == '0) ? cfg.steps_per_rev : position_reg;
    assign pos_down = pos_base - POS_W'(1);

    assign remaining_dec = remaining_reg - (MOVE_BITS+1)'(1);

    always_comb
    begin
        position_next    = position_reg;
        remaining_next   = remaining_reg;
        period_next      = period_reg;
        direction_next   = direction_reg;
        moving_next      = moving_reg;
        armed_next       = armed_reg;
        armed_level_next = armed_level_reg;
        halted_next      = halted_reg;
        case (op)
            ssdg_pkg::OP_TICK:
            begin
                if (moving_reg)
                begin
                    if (period_end)
                    begin
                        period_next = '0;
                        if (armed_reg && (limit_level == armed_level_reg))
                        begin
                            // Stop on the limit switch
                            moving_next = 1'b0;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            position_next  = direction_reg ? pos_up : pos_down;
                            remaining_next = remaining_dec;
                            if (remaining_dec == '0)
                                moving_next = 1'b0;
                        end
                    end
                    else
                    begin
                        period_next = period_sum[PERIOD_W-1:0];
                    end
                end
            end
            ssdg_pkg::OP_START,
            ssdg_pkg::OP_START_LIMIT:
            begin
                if (!move_zero)
                begin
                    // Abort any move in progress and load the new one
                    remaining_next   = {magnitude, 1'b0};
                    direction_next   = (!negative) ^ cfg.invert_direction;
                    moving_next      = 1'b1;
                    halted_next      = 1'b0;
                    period_next      = '0;
                    armed_next       = (op == ssdg_pkg::OP_START_LIMIT);
                    armed_level_next = (op == ssdg_pkg::OP_START_LIMIT) && stop_level;
                end
            end
            default:
            begin
                position_next = position_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            remaining_reg   <= '0;
            period_reg      <= '0;
            direction_reg   <= 1'b0;
            moving_reg      <= 1'b0;
            armed_reg       <= 1'b0;
            armed_level_reg <= 1'b0;
            halted_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            position_reg    <= position_next;
            remaining_reg   <= remaining_next;
            period_reg      <= period_next;
            direction_reg   <= direction_next;
            moving_reg      <= moving_next;
            armed_reg       <= armed_next;
            armed_level_reg <= armed_level_next;
            halted_reg      <= halted_next;
        end
    end

    // Report the state as it stands after this item
    always_comb
    begin
        status_next.step_level = position_next[0];
        status_next.dir_level  = direction_next;
        status_next.busy       = moving_next;
        status_next.halted     = halted_next;
        status_next.position   = position_next;
    end

endmodule

[design/stepper_step_dir_generator.sv]
`timescale 1ns / 1ps

// Step/direction pulse generator for a stepper driver. Each input item is
// either a microsecond tick (op 0) or a start command (op 1, or op 2 with a
// limit-switch stop level); every item yields one result with the step,
// direction and enable pin levels, the busy and limit-halt flags and the
// position counter as they stand after that item. The block accepts one item
// per clock while the result side is not stalled, and passes each item
// through the input register, then the motion-state update into the result
// register. A stalled result holds in the result register while the input
// register takes the next item. Configuration writes are always taken and
// must arrive only while no item is in flight.
module stepper_step_dir_generator
#(
    parameter int MOVE_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssdg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic signed [MOVE_BITS-1:0]     move_steps,
    input  logic                            stop_level,
    input  logic                            limit_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            step_level,
    output logic                            dir_level,
    output logic                            enable_level,
    output logic                            busy_res,
    output logic                            halted_by_switch,
    output logic [ssdg_pkg::POS_W-1:0]      position
);

    ssdg_pkg::cfg_t       cfg;
    ssdg_pkg::status_t    status_next;
    ssdg_pkg::status_t    res_reg;
    logic                 enable_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 item_valid;
    logic                 step_en;
    logic [1:0]           op_q;
    logic [MOVE_BITS-1:0] move_q;
    logic                 stop_q;
    logic                 limit_q;

    assign cfg_ready = 1'b1;

    ssdg_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register is free when empty or being emptied
    assign out_free = !out_valid_reg || out_ready;
    assign step_en  = item_valid && out_free;

    ssdg_in_stage #(.MOVE_BITS(MOVE_BITS)) u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .move_steps  (move_steps),
        .stop_level  (stop_level),
        .limit_level (limit_level),
        .advance     (out_free),
        .item_valid  (item_valid),
        .op_q        (op_q),
        .move_q      (move_q),
        .stop_q      (stop_q),
        .limit_q     (limit_q)
    );

    ssdg_motion_core #(.MOVE_BITS(MOVE_BITS)) u_motion_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .op          (op_q),
        .move_steps  (move_q),
        .stop_level  (stop_q),
        .limit_level (limit_q),
        .cfg         (cfg),
        .status_next (status_next)
    );

    // Result valid: load with each processed item, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg    <= status_next;
            enable_reg <= !cfg.driver_enable;
        end
    end

    assign out_valid        = out_valid_reg;
    assign step_level       = res_reg.step_level;
    assign dir_level        = res_reg.dir_level;
    assign enable_level     = enable_reg;
    assign busy_res         = res_reg.busy;
    assign halted_by_switch = res_reg.halted;
    assign position         = res_reg.position;

endmodule

[design/ssdg_checker.sv]
`timescale 1ns / 1ps
`include "stepper_step_dir_generator_macros.svh"

module ssdg_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       step_level,
    input logic                       busy_res,
    input logic                       halted_by_switch,
    input logic [ssdg_pkg::POS_W-1:0] position
);

    // A stalled result stays and keeps its position
    `SSDG_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(position), "stalled result changed")

    // The step pin follows the low bit of the position
    `SSDG_ASSERT_IMPLY(a_step_is_lsb, clk, rst_n, out_valid, step_level == position[0], "step pin differs from position bit")

    // A limit halt always ends the move
    `SSDG_ASSERT_IMPLY(a_halt_not_busy, clk, rst_n, out_valid && halted_by_switch, !busy_res, "busy after limit halt")

    // With the result side empty the block must take an item
    `SSDG_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind stepper_step_dir_generator ssdg_checker u_ssdg_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .step_level       (step_level),
    .busy_res         (busy_res),
    .halted_by_switch (halted_by_switch),
    .position         (position)
);
